### hdl/hld_pkg.sv
// ----------------------------------------------------------------------------
// hld_pkg
// Shared widths, register indexes, reset values and control structs for the
// hysteresis lockout dimmer.
// ----------------------------------------------------------------------------
package hld_pkg;

  localparam int THRESH_W   = 12;
  localparam int DUTY_W     = 16;
  localparam int LOCKOUT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR     = 3'd4;

  localparam logic [THRESH_W-1:0]  RST_THRESHOLD_LOW  = 12'd1000;
  localparam logic [THRESH_W-1:0]  RST_THRESHOLD_HIGH = 12'd1500;
  localparam logic [LOCKOUT_W-1:0] RST_LOCKOUT_MS     = 16'd500;
  localparam logic [DUTY_W-1:0]    RST_DUTY_MAX       = 16'd255;
  localparam logic [DUTY_W-1:0]    RST_DUTY_FLOOR     = 16'd100;

  // Lamp decision for the request being taken
  typedef struct packed {
    logic led_on;
    logic toggled;
  } hld_flags_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } hld_div_stat_t;

endpackage

### hdl/hld_sample_if.sv
// ----------------------------------------------------------------------------
// hld_sample_if
// Request channel: one light sample with its millisecond timestamp.
// ----------------------------------------------------------------------------
interface hld_sample_if #(
  parameter int ADC_BITS  = 12,
  parameter int TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [ADC_BITS-1:0]  level;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, output level, output now_ms, input ready);
  modport sink   (input valid, input level, input now_ms, output ready);
endinterface

### hdl/hld_result_if.sv
// ----------------------------------------------------------------------------
// hld_result_if
// Result channel: LED state, PWM duty and toggle flag.
// ----------------------------------------------------------------------------
interface hld_result_if;
  logic                       valid;
  logic                       ready;
  logic                       led_on;
  logic [hld_pkg::DUTY_W-1:0] duty;
  logic                       toggled;

  modport source (output valid, output led_on, output duty, output toggled, input ready);
  modport sink   (input valid, input led_on, input duty, input toggled, output ready);
endinterface

### hdl/hld_cfg_if.sv
// ----------------------------------------------------------------------------
// hld_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hld_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hld_pkg::CFG_IDX_W-1:0]  index;
  logic [hld_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/hld_serial_div.sv
// ----------------------------------------------------------------------------
// hld_serial_div
// Restoring divider, one quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
module hld_serial_div #(
  parameter int N_W = 28,
  parameter int D_W = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [N_W-1:0]         dividend,
  input  logic [D_W-1:0]         divisor,
  output logic [N_W-1:0]         quotient,
  output hld_pkg::hld_div_stat_t stat
);
  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   dq;
  logic [D_W-1:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [D_W:0]     sh;
  logic [D_W:0]     diff;
  logic             ge;

  // Bring down the next dividend bit and try the subtraction
  assign sh   = {rem, dq[N_W-1]};
  assign ge   = sh >= {1'b0, divisor};
  assign diff = sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
    end else if (busy) begin
      dq  <= {dq[N_W-2:0], ge};
      rem <= ge ? diff[D_W-1:0] : sh[D_W-1:0];
    end
  end

  assign quotient  = dq;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### hdl/hld_toggle_ctl.sv
// ----------------------------------------------------------------------------
// hld_toggle_ctl
// Hysteresis and lockout decision; holds lamp state and last toggle time.
// ----------------------------------------------------------------------------
module hld_toggle_ctl #(
  parameter int ADC_BITS  = 12,
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic [ADC_BITS-1:0]             level,
  input  logic [TIME_BITS-1:0]            now,
  input  logic [hld_pkg::THRESH_W-1:0]    threshold_low,
  input  logic [hld_pkg::THRESH_W-1:0]    threshold_high,
  input  logic [hld_pkg::LOCKOUT_W-1:0]   lockout_ms,
  output hld_pkg::hld_flags_t             flags
);
  localparam int CMP_W = (ADC_BITS > hld_pkg::THRESH_W) ? ADC_BITS : hld_pkg::THRESH_W;

  logic                 lamp_state;
  logic [TIME_BITS-1:0] last_toggle_time;
  logic [TIME_BITS-1:0] elapsed;
  logic                 time_ok;
  logic                 go_on;
  logic                 go_off;

  // Elapsed time wraps with the timestamp
  assign elapsed = now - last_toggle_time;
  assign time_ok = elapsed >= TIME_BITS'(lockout_ms);
  assign go_on   = !lamp_state && (CMP_W'(level) < CMP_W'(threshold_low)) && time_ok;
  assign go_off  = lamp_state && (CMP_W'(level) > CMP_W'(threshold_high)) && time_ok;

  assign flags.toggled = go_on || go_off;
  assign flags.led_on  = lamp_state ^ (go_on || go_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_state       <= 1'b0;
      last_toggle_time <= '0;
    end else if (take && (go_on || go_off)) begin
      lamp_state       <= !lamp_state;
      last_toggle_time <= now;
    end
  end

endmodule

### hdl/hysteresis_lockout_dimmer_core.sv
// A request is taken only in the idle state, so the next one waits until the previous
// result has moved into the output register; the bit-serial divider produces one
//   quotient bit per cycle over ADC_BITS + 16 bits.
// A new request is taken while the previous result still waits at the output.
// Reset (rst, synchronous, active high): LED off, last toggle time 0,
//   registers back to 1000 / 1500 / 500 / 255 / 100.
// ----------------------------------------------------------------------------
// hysteresis_lockout_dimmer_core
// Light-driven LED switch with hysteresis, toggle lockout and a dimming
// duty that falls linearly with the light level while the floor is below max.
// ----------------------------------------------------------------------------
module hysteresis_lockout_dimmer_core #(
  parameter int ADC_BITS  = 12,
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  hld_sample_if.sink          sample,
  hld_result_if.source        result,
  hld_cfg_if.sink             cfg
);
  localparam int DW  = hld_pkg::DUTY_W;
  localparam int N_W = ADC_BITS + DW;

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Configuration registers
  logic [hld_pkg::THRESH_W-1:0]  threshold_low;
  logic [hld_pkg::THRESH_W-1:0]  threshold_high;
  logic [hld_pkg::LOCKOUT_W-1:0] lockout_ms;
  logic [DW-1:0]                 duty_max;
  logic [DW-1:0]                 duty_floor;

  logic [1:0]                    st;
  logic                          take;
  hld_pkg::hld_flags_t           flags;
  hld_pkg::hld_flags_t           flags_r;
  hld_pkg::hld_div_stat_t        div_stat;
  logic [ADC_BITS-1:0]           level_r;
  logic [DW-1:0]                 dmag;
  logic                          d_neg;
  logic [N_W-1:0]                prod;
  logic [N_W-1:0]                quot;
  logic [DW-1:0]                 duty_calc;
  logic [DW-1:0]                 duty_pend;
  logic                          res_valid;
  logic                          res_led;
  logic                          res_toggled;
  logic [DW-1:0]                 res_duty;
  logic                          out_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_low  <= hld_pkg::RST_THRESHOLD_LOW;
      threshold_high <= hld_pkg::RST_THRESHOLD_HIGH;
      lockout_ms     <= hld_pkg::RST_LOCKOUT_MS;
      duty_max       <= hld_pkg::RST_DUTY_MAX;
      duty_floor     <= hld_pkg::RST_DUTY_FLOOR;
    end else if (cfg.valid) begin
      case (cfg.index)
        hld_pkg::REG_THRESHOLD_LOW:  threshold_low  <= cfg.data[hld_pkg::THRESH_W-1:0];
        hld_pkg::REG_THRESHOLD_HIGH: threshold_high <= cfg.data[hld_pkg::THRESH_W-1:0];
        hld_pkg::REG_LOCKOUT_MS:     lockout_ms     <= cfg.data;
        hld_pkg::REG_DUTY_MAX:       duty_max       <= cfg.data;
        hld_pkg::REG_DUTY_FLOOR:     duty_floor     <= cfg.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Slope magnitude and sign follow the configuration; config is to move only
  // while idle (the block does not enforce it), so this is settled before the multiply.
  always_ff @(posedge clk) begin
    d_neg <= duty_floor < duty_max;
    dmag  <= (duty_floor < duty_max) ? duty_max - duty_floor : duty_floor - duty_max;
  end

  // Hysteresis decision happens as the request is taken
  assign take         = sample.valid && sample.ready;
  assign sample.ready = (st == ST_IDLE);

  hld_toggle_ctl #(
    .ADC_BITS  (ADC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_toggle (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .level          (sample.level),
    .now            (sample.now_ms),
    .threshold_low  (threshold_low),
    .threshold_high (threshold_high),
    .lockout_ms     (lockout_ms),
    .flags          (flags)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      level_r <= sample.level;
      flags_r <= flags;
    end
  end

  // Product level * |floor - max| loads straight into the divider
  assign prod = level_r * dmag;

  hld_serial_div #(
    .N_W (N_W),
    .D_W (hld_pkg::THRESH_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (st == ST_MUL),
    .dividend (prod),
    .divisor  (threshold_low),
    .quotient (quot),
    .stat     (div_stat)
  );

  // Off gives 0, a zero low threshold gives floor; else ordered clamp per slope sign:
  //   rising (floor >= max): quotient below slope gives floor, else max
  //   falling:               quotient above slope gives floor, else max - quotient
  always_comb begin
    if (!flags_r.led_on) begin
      duty_calc = '0;
    end else if (threshold_low == '0) begin
      duty_calc = duty_floor;
    end else if (!d_neg) begin
      duty_calc = (quot < N_W'(dmag)) ? duty_floor : duty_max;
    end else begin
      duty_calc = (quot > N_W'(dmag)) ? duty_floor : duty_max - quot[DW-1:0];
    end
  end

  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      case (st)
        ST_IDLE: if (take) st <= ST_MUL;
        ST_MUL:  st <= ST_DIV;
        ST_DIV:  if (div_stat.done) st <= ST_DONE;
        ST_DONE: if (out_free) st <= ST_IDLE;
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Hold the finished duty until the output slot frees up
  always_ff @(posedge clk) begin
    if (st == ST_DIV && div_stat.done) begin
      duty_pend <= duty_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (st == ST_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_DONE && out_free) begin
      res_led     <= flags_r.led_on;
      res_toggled <= flags_r.toggled;
      res_duty    <= duty_pend;
    end
  end

  assign result.valid   = res_valid;
  assign result.led_on  = res_led;
  assign result.duty    = res_duty;
  assign result.toggled = res_toggled;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hysteresis lockout dimmer core. A short table
// of directed requests and register writes is followed by eight random
// phases. Each phase loads new settings and changes how often the sample
// side idles and the result side stalls. A local model of the lamp decision
// and the dimming duty predicts every result that the table does not give. The
// monitor compares results in order, field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int STAMP_W     = 32;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 112;
  localparam int HOLD_CYCLES = 400;   // long result-side hold-off
  localparam int TAIL_CYCLES = 40;    // idle tail after the last result is back
  localparam int QUIET_LIMIT = 5000;  // cycles without any handshake

  localparam logic [hld_pkg::THRESH_W-1:0]  LEVEL_MAX    = '1;
  localparam logic [hld_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;  // unmapped register indexes
  localparam logic [hld_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                       led;
    logic [hld_pkg::DUTY_W-1:0] duty;
    logic                       tog;
  } lamp_out_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [hld_pkg::CFG_IDX_W-1:0]  idx;
    logic [hld_pkg::CFG_DATA_W-1:0] data;
    logic [hld_pkg::THRESH_W-1:0]   level;
    logic [STAMP_W-1:0]             stamp;
    logic                           typed;  // expected result given in the row
    lamp_out_t                      out;
  } stim_row_t;

  // Directed walk, starting from the reset settings 1000 / 1500 / 500 / 255 / 100.
  localparam int STIM_ROWS = 31;
  localparam stim_row_t STIM [STIM_ROWS] = '{
    // lamp off and not yet clear of the lockout: bright, then dark
    '{ROW_SAMPLE, '0, '0, 12'd4095, 32'd0,          1'b1, '{1'b0, 16'd0,   1'b0}},
    '{ROW_SAMPLE, '0, '0, 12'd0,    32'd499,        1'b1, '{1'b0, 16'd0,   1'b0}},
    // lockout just met: switch on at full duty
    '{ROW_SAMPLE, '0, '0, 12'd0,    32'd500,        1'b1, '{1'b1, 16'd255, 1'b1}},
    // bright inside the lockout: stay on, duty clamped to the floor; then off once clear
    '{ROW_SAMPLE, '0, '0, 12'd4095, 32'd999,        1'b1, '{1'b1, 16'd100, 1'b0}},
    '{ROW_SAMPLE, '0, '0, 12'd4095, 32'd1000,       1'b1, '{1'b0, 16'd0,   1'b1}},
    // switch on right at the top of the clock; the quotient truncates toward zero
    '{ROW_SAMPLE, '0, '0, 12'd999,  32'hFFFF_FFFF,  1'b0, '0},
    // elapsed time across the clock wrap, one short of the lockout and then on it
    '{ROW_SAMPLE, '0, '0, 12'd1501, 32'd498,        1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 12'd1501, 32'd499,        1'b0, '0},
    // level equal to the low threshold does not count as dark
    '{ROW_SAMPLE, '0, '0, 12'd1000, 32'd2000,       1'b1, '{1'b0, 16'd0,   1'b0}},
    // no lockout, floor above max, thresholds at the top (upper data bits dropped)
    '{ROW_WRITE,  hld_pkg::REG_LOCKOUT_MS,     16'h0000, '0, '0, 1'b0, '0},
    '{ROW_WRITE,  hld_pkg::REG_DUTY_FLOOR,     16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_WRITE,  hld_pkg::REG_DUTY_MAX,       16'h0000, '0, '0, 1'b0, '0},
    '{ROW_WRITE,  hld_pkg::REG_THRESHOLD_LOW,  16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_WRITE,  hld_pkg::REG_THRESHOLD_HIGH, 16'h0FFF, '0, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 12'd0,    32'd2000,       1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 12'd4094, 32'd2000,       1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 12'd4095, 32'd2000,       1'b0, '0},
    // zero low threshold: the duty while on is the floor
    '{ROW_WRITE,  hld_pkg::REG_THRESHOLD_LOW,  16'hF000, '0, '0, 1'b0, '0},
    '{ROW_WRITE,  hld_pkg::REG_DUTY_MAX,       16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_WRITE,  hld_pkg::REG_DUTY_FLOOR,     16'h0000, '0, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 12'd2048, 32'd2000,       1'b1, '{1'b1, 16'd0,   1'b0}},
    // unmapped indexes must leave every register alone
    '{ROW_WRITE,  IDX_SPARE_LO,                16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_WRITE,  IDX_SPARE_HI,                16'h0000, '0, '0, 1'b0, '0},
    '{ROW_WRITE,  hld_pkg::REG_THRESHOLD_HIGH, 16'hF000, '0, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 12'd0,    32'd2000,       1'b1, '{1'b1, 16'd0,   1'b0}},
    '{ROW_SAMPLE, '0, '0, 12'd1,    32'd2000,       1'b1, '{1'b0, 16'd0,   1'b1}},
    '{ROW_SAMPLE, '0, '0, 12'd0,    32'd2000,       1'b1, '{1'b0, 16'd0,   1'b0}},
    // widest lockout, one short and then exactly on it
    '{ROW_WRITE,  hld_pkg::REG_THRESHOLD_LOW,  16'h0800, '0, '0, 1'b0, '0},
    '{ROW_WRITE,  hld_pkg::REG_LOCKOUT_MS,     16'hFFFF, '0, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 12'd2047, 32'd67534,      1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 12'd2047, 32'd67535,      1'b0, '0}
  };

  // Idle and stall percentages per phase, cycling through the four modes.
  localparam int SRC_IDLE [4] = '{0, 52, 0, 32};
  localparam int RCV_STALL [4] = '{0, 0, 52, 32};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic take_ready = 1'b0;

  // Local copy of the settings and the lamp state, reset values to start with
  logic [hld_pkg::THRESH_W-1:0]  thr_low  = hld_pkg::RST_THRESHOLD_LOW;
  logic [hld_pkg::THRESH_W-1:0]  thr_high = hld_pkg::RST_THRESHOLD_HIGH;
  logic [hld_pkg::LOCKOUT_W-1:0] lock_ms  = hld_pkg::RST_LOCKOUT_MS;
  logic [hld_pkg::DUTY_W-1:0]    duty_top = hld_pkg::RST_DUTY_MAX;
  logic [hld_pkg::DUTY_W-1:0]    duty_min = hld_pkg::RST_DUTY_FLOOR;
  logic                          lamp      = 1'b0;
  logic [STAMP_W-1:0]            last_flip = '0;
  logic [STAMP_W-1:0]            stamp_now = '0;

  lamp_out_t pending_lamp [$];
  int fails         = 0;
  int src_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_asks     = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  hld_sample_if #(.ADC_BITS(hld_pkg::THRESH_W), .TIME_BITS(STAMP_W)) sample_ch ();
  hld_result_if result_ch ();
  hld_cfg_if    cfg_ch ();

  assign result_ch.ready = take_ready;

  hysteresis_lockout_dimmer_core #(
    .ADC_BITS  (hld_pkg::THRESH_W),
    .TIME_BITS (STAMP_W)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // Lamp decision and dimming duty for one request; advances the local state.
  function automatic lamp_out_t lamp_step(input logic [hld_pkg::THRESH_W-1:0] lvl,
                                          input logic [STAMP_W-1:0] stamp);
    lamp_out_t          o;
    logic [STAMP_W-1:0] gone;
    logic               may_flip;
    longint             lv, thr, top, bot, v;
    gone     = stamp - last_flip;                 // wraps modulo 2^32
    may_flip = (gone >= STAMP_W'(lock_ms));
    o        = '0;
    if (!lamp && lvl < thr_low && may_flip) begin
      lamp      = 1'b1;
      last_flip = stamp;
      o.tog     = 1'b1;
    end else if (lamp && lvl > thr_high && may_flip) begin
      lamp      = 1'b0;
      last_flip = stamp;
      o.tog     = 1'b1;
    end
    o.led = lamp;
    if (lamp) begin
      if (thr_low == '0) begin
        o.duty = duty_min;
      end else begin
        // signed straight line from max at level 0 to floor at the low threshold
        lv  = lvl;
        thr = thr_low;
        top = duty_top;
        bot = duty_min;
        v   = lv * (bot - top) / thr + top;
        // clamp in this order, so a floor above max still wins below it
        if (v < bot) o.duty = duty_min;
        else if (v > top) o.duty = duty_top;
        else o.duty = v[hld_pkg::DUTY_W-1:0];
      end
    end
    return o;
  endfunction

  // Level that mostly tries to flip the lamp, sometimes lands within two of a threshold.
  function automatic logic [hld_pkg::THRESH_W-1:0] pick_level();
    int r;
    int t;
    r = $urandom_range(99);
    if (r < 70 && !lamp && thr_low != '0)
      return hld_pkg::THRESH_W'($urandom_range(thr_low - 1, 0));
    if (r < 70 && lamp && thr_high != LEVEL_MAX)
      return hld_pkg::THRESH_W'($urandom_range(LEVEL_MAX, thr_high + 1));
    if (r >= 70 && r < 85) begin
      t = (lamp ? int'(thr_high) : int'(thr_low)) + int'($urandom_range(4)) - 2;
      if (t < 0) t = 0;
      if (t > int'(LEVEL_MAX)) t = LEVEL_MAX;
      return hld_pkg::THRESH_W'(t);
    end
    return hld_pkg::THRESH_W'($urandom);
  endfunction

  // Advance the millisecond clock: mostly short steps against the lockout.
  function automatic logic [STAMP_W-1:0] next_stamp();
    int unsigned r;
    int unsigned span;
    r    = $urandom_range(99);
    span = lock_ms;
    if (r < 70) stamp_now += $urandom_range(span / 2 + 1);
    else if (r < 90) stamp_now += $urandom_range(2 * span + 2);
    else if (r >= 97) stamp_now += $urandom;
    return stamp_now;
  endfunction

  // Offer one request, with random idle cycles first; valid stays high after
  // the handshake so that a following request can go straight out.
  task automatic offer_sample(input logic [hld_pkg::THRESH_W-1:0] lvl,
                              input logic [STAMP_W-1:0] stamp,
                              input logic typed, input lamp_out_t typed_out);
    lamp_out_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.level  <= lvl;
    sample_ch.now_ms <= stamp;
    do @(posedge clk); while (!sample_ch.ready);
    want = lamp_step(lvl, stamp);
    pending_lamp.push_back(typed ? typed_out : want);
  endtask

  // Write one register; valid is left high and dropped by the caller.
  task automatic post_write(input logic [hld_pkg::CFG_IDX_W-1:0] idx,
                            input logic [hld_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      hld_pkg::REG_THRESHOLD_LOW:  thr_low  = val[hld_pkg::THRESH_W-1:0];
      hld_pkg::REG_THRESHOLD_HIGH: thr_high = val[hld_pkg::THRESH_W-1:0];
      hld_pkg::REG_LOCKOUT_MS:     lock_ms  = val[hld_pkg::LOCKOUT_W-1:0];
      hld_pkg::REG_DUTY_MAX:       duty_top = val[hld_pkg::DUTY_W-1:0];
      hld_pkg::REG_DUTY_FLOOR:     duty_min = val[hld_pkg::DUTY_W-1:0];
      default: ;
    endcase
  endtask

  // Drop the request line and hold until every expected result is back.
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_lamp.size() != 0);
  endtask

  // Settings for one random phase; phase 3 takes the extremes.
  task automatic load_phase_config(input int ph);
    logic [hld_pkg::THRESH_W-1:0]   tl, th;
    logic [hld_pkg::LOCKOUT_W-1:0]  lo;
    logic [hld_pkg::DUTY_W-1:0]     mx, fl;
    logic [hld_pkg::CFG_DATA_W-1:0] junk;
    junk = hld_pkg::CFG_DATA_W'($urandom);
    tl   = hld_pkg::THRESH_W'($urandom);
    th   = hld_pkg::THRESH_W'($urandom);
    lo   = hld_pkg::LOCKOUT_W'($urandom_range(1000));
    mx   = hld_pkg::DUTY_W'($urandom);
    fl   = hld_pkg::DUTY_W'($urandom);
    if (ph == 0) begin
      // ordinary hysteresis band with a short lockout
      tl = hld_pkg::THRESH_W'($urandom_range(2000, 200));
      th = tl + hld_pkg::THRESH_W'($urandom_range(800));
      lo = hld_pkg::LOCKOUT_W'($urandom_range(300));
    end else if (ph == 3) begin
      // inverted band, no lockout, widest duty span: the lamp flips on almost every request
      tl = LEVEL_MAX;
      th = '0;
      lo = '0;
      mx = '1;
      fl = '0;
    end else if (ph == 6) begin
      lo = '1;
    end
    if (ph == 1) stamp_now = $urandom;
    if (ph == 4) stamp_now = 32'hFFFF_FFFF - $urandom_range(2000);  // cross the wrap
    // junk fills the unused upper data bits of the threshold writes
    post_write(hld_pkg::REG_THRESHOLD_LOW,  {junk[15:12], tl});
    post_write(hld_pkg::REG_THRESHOLD_HIGH, {junk[11:8], th});
    post_write(hld_pkg::REG_LOCKOUT_MS,     lo);
    post_write(hld_pkg::REG_DUTY_MAX,       mx);
    post_write(hld_pkg::REG_DUTY_FLOOR,     fl);
    if (ph % 2 == 1)
      post_write(hld_pkg::CFG_IDX_W'($urandom_range(IDX_SPARE_HI, IDX_SPARE_LO)), junk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      take_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      take_ready <= 1'b0;
    end else begin
      take_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin : check_result
    lamp_out_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_lamp.size() == 0) begin
        $error("result with nothing expected: led_on %0d duty %0d toggled %0d",
               result_ch.led_on, result_ch.duty, result_ch.toggled);
        fails++;
      end else begin
        want = pending_lamp.pop_front();
        if (result_ch.led_on !== want.led) begin
          $error("led_on: expected %0d, got %0d", want.led, result_ch.led_on);
          fails++;
        end
        if (result_ch.duty !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, result_ch.duty);
          fails++;
        end
        if (result_ch.toggled !== want.tog) begin
          $error("toggled: expected %0d, got %0d", want.tog, result_ch.toggled);
          fails++;
        end
      end
    end
  end

  // Watchdog: give up once no channel has moved anything for too long.
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    logic      writing;
    // hold every input at a known value from the very start
    sample_ch.valid  = 1'b0;
    sample_ch.level  = '0;
    sample_ch.now_ms = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    writing          = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed walk: drain before a run of writes, drop the write line after it
    for (int r = 0; r < STIM_ROWS; r++) begin
      row = STIM[r];
      if (row.kind == ROW_WRITE) begin
        if (!writing) drain_results();
        post_write(row.idx, row.data);
        writing = 1'b1;
      end else begin
        if (writing) cfg_ch.valid <= 1'b0;
        writing = 1'b0;
        offer_sample(row.level, row.stamp, row.typed, row.out);
      end
    end
    if (writing) cfg_ch.valid <= 1'b0;

    // Random phases, each with fresh settings and its own idling mode
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      load_phase_config(ph);
      src_idle_pct  = SRC_IDLE[ph % 4];
      rcv_stall_pct = RCV_STALL[ph % 4];
      // hold the result side off while requests keep coming, to fill the block
      if (ph == 2) hold_asks++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        offer_sample(pick_level(), next_stamp(), 1'b0, '0);
        // pause the requests midway until everything outstanding is back
        if (ph == 5 && n == PHASE_ITEMS / 2) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
hdl/hld_pkg.sv
hdl/hld_sample_if.sv
hdl/hld_result_if.sv
hdl/hld_cfg_if.sv
hdl/hld_serial_div.sv
hdl/hld_toggle_ctl.sv
hdl/hysteresis_lockout_dimmer_core.sv
tb/tb.sv
